### rtl/core/srs_pkg.sv
// shared types and constants of the stable record sorter
package srs_pkg;

  localparam int unsigned MaxRecordsDef = 64;
  localparam int unsigned KeyW          = 8;
  localparam int unsigned ScoreW        = 10;
  localparam int unsigned TagW          = 6;
  localparam logic [ScoreW-1:0] TotalScoreRst = 10'd100;

  // input beat
  typedef struct packed {
    logic [KeyW-1:0]   sort_key;
    logic [ScoreW-1:0] score;
    logic [TagW-1:0]   record_tag;
    logic              is_last;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic [TagW-1:0]   out_tag;
    logic [ScoreW-1:0] out_score;
    logic              passed;
    logic [ScoreW-1:0] best_score;
    logic [TagW-1:0]   best_tag;
    logic              overflowed;
    logic              last_out;
  } out_beat_t;

  // one stored record
  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [ScoreW-1:0] score;
    logic [TagW-1:0]   tag;
  } rec_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

endpackage

### rtl/core/srs_cell.sv
// one cell of the sorting chain: holds one record and its valid bit
module srs_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srs_pkg::cell_ctl_t ctl_i,
  input  srs_pkg::rec_t     new_rec_i,
  input  srs_pkg::rec_t     left_rec_i,
  input  logic              left_valid_i,
  input  logic              left_gt_i,
  input  srs_pkg::rec_t     right_rec_i,
  input  logic              right_valid_i,
  output srs_pkg::rec_t     rec_o,
  output logic              valid_o,
  output logic              gt_o
);
  import srs_pkg::*;

  rec_t rec_q, rec_d;
  logic valid_q, valid_d;
  logic take;

  // stored key strictly above the new key: this cell moves one place right
  assign gt_o = valid_q && (rec_q.key > new_rec_i.key);

  // cell takes a record when it moves right or is the first empty slot
  assign take = gt_o || (!valid_q && left_valid_i);

  always_comb begin
    rec_d   = rec_q;
    valid_d = valid_q;
    if (ctl_i.shift) begin
      rec_d   = right_rec_i;
      valid_d = right_valid_i;
    end else if (ctl_i.insert && take) begin
      rec_d   = left_gt_i ? left_rec_i : new_rec_i;
      valid_d = 1'b1;
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // record payload
  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o   = rec_q;
  assign valid_o = valid_q;

endmodule

### rtl/core/stable_record_sorter_with_max.sv
// top level of the stable record sorter with best-score tracking
//
// Input channel in_valid_i / in_stall_o / in_data_i carries one record per
// beat. Records are inserted into a chain of cells kept sorted by key, equal
// keys in arrival order, one beat per cycle. A beat with is_last set is
// loaded too and then starts emission: the chain shifts toward cell 0 and
// one sorted record per cycle, unless the output stalls, moves into the
// output register; the first output beat passes the state register and
// then the output register after the last input beat was taken. While a
// set is emitted in_stall_o is high; the next set may start loading from
// the cycle after the final beat has been moved into the output register.
// A stall on out_stall_i holds the output beat and pauses the chain. Records
// beyond MAX_RECORDS are dropped and reported by overflowed. cfg_we_i writes
// total_score; the pass threshold is half of it, rounded down. Reset empties
// the chain, clears the best score and sets total_score to 100.
module stable_record_sorter_with_max #(
  parameter int unsigned MAX_RECORDS = srs_pkg::MaxRecordsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [srs_pkg::ScoreW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  srs_pkg::in_beat_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output srs_pkg::out_beat_t        out_data_o
);
  import srs_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_RECORDS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_RECORDS);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [ScoreW-1:0] top_score_q, top_score_d;
  logic [TagW-1:0]   top_tag_q, top_tag_d;
  logic              drop_q, drop_d;
  logic [ScoreW-1:0] total_q;
  logic              out_valid_q, out_valid_d;
  out_beat_t         out_q, out_d;

  logic      in_acc, full, emit_step;
  rec_t      new_rec;
  cell_ctl_t ctl;

  rec_t                   cell_rec [MAX_RECORDS];
  logic [MAX_RECORDS-1:0] cell_valid;
  logic [MAX_RECORDS-1:0] cell_gt;

  assign in_stall_o = (state_q != ST_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CntMax);
  assign emit_step  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  assign new_rec.key   = in_data_i.sort_key;
  assign new_rec.score = in_data_i.score;
  assign new_rec.tag   = in_data_i.record_tag;

  assign ctl.insert = in_acc && !full;
  assign ctl.shift  = emit_step;

  // chain of cells, cell 0 holds the smallest key
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    rec_t left_rec, right_rec;
    logic left_valid, left_gt, right_valid;
    if (i == 0) begin : g_first
      assign left_rec   = new_rec;
      assign left_valid = 1'b1;
      assign left_gt    = 1'b0;
    end else begin : g_mid_l
      assign left_rec   = cell_rec[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_gt    = cell_gt[i-1];
    end
    if (i == MAX_RECORDS - 1) begin : g_last
      assign right_rec   = new_rec;
      assign right_valid = 1'b0;
    end else begin : g_mid_r
      assign right_rec   = cell_rec[i+1];
      assign right_valid = cell_valid[i+1];
    end
    srs_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .new_rec_i     (new_rec),
      .left_rec_i    (left_rec),
      .left_valid_i  (left_valid),
      .left_gt_i     (left_gt),
      .right_rec_i   (right_rec),
      .right_valid_i (right_valid),
      .rec_o         (cell_rec[i]),
      .valid_o       (cell_valid[i]),
      .gt_o          (cell_gt[i])
    );
  end

  // set bookkeeping and sequencing
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    top_score_d = top_score_q;
    top_tag_d   = top_tag_q;
    drop_d      = drop_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            count_d = count_q + CntOne;
            if (count_q == '0 || in_data_i.score > top_score_q) begin
              top_score_d = in_data_i.score;
              top_tag_d   = in_data_i.record_tag;
            end
          end
          if (in_data_i.is_last) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (emit_step) begin
          count_d = count_q - CntOne;
          if (count_q == CntOne) begin
            state_d     = ST_LOAD;
            top_score_d = '0;
            top_tag_d   = '0;
            drop_d      = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit_step) begin
      out_valid_d      = 1'b1;
      out_d.out_tag    = cell_rec[0].tag;
      out_d.out_score  = cell_rec[0].score;
      out_d.passed     = (cell_rec[0].score >= {1'b0, total_q[ScoreW-1:1]});
      out_d.best_score = top_score_q;
      out_d.best_tag   = top_tag_q;
      out_d.overflowed = drop_q;
      out_d.last_out   = (count_q == CntOne);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      top_score_q <= '0;
      top_tag_q   <= '0;
      drop_q      <= 1'b0;
      total_q     <= TotalScoreRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      top_score_q <= top_score_d;
      top_tag_q   <= top_tag_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(count_q))
    else $error("record count differs from occupied cells");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("record count above capacity");

  a_emit_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> count_q != '0)
    else $error("emission with an empty chain");

  a_final_beat_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_step && count_q == CntOne |=> state_q == ST_LOAD && count_q == '0 && !drop_q)
    else $error("set not cleared after final beat");

endmodule

### dv/srs_tb_pkg.sv
// scoreboard that predicts the sorted output rows of the record sorter
package srs_tb_pkg;
  import srs_pkg::*;

  class sorted_roster;
    int unsigned capacity;
    logic [ScoreW-1:0] total_score;
    // records of the set being loaded, kept in stable key order
    rec_t roster[$];
    logic [ScoreW-1:0] top_score;
    logic [TagW-1:0] top_tag;
    logic dropped;
    out_beat_t expected_rows[$];
    int mismatches;

    function new(int unsigned cap);
      capacity = cap;
      total_score = TotalScoreRst;
      top_score = '0;
      top_tag = '0;
      dropped = 1'b0;
      mismatches = 0;
    endfunction

    function void set_total(logic [ScoreW-1:0] value);
      total_score = value;
    endfunction

    function int pending();
      return expected_rows.size();
    endfunction

    // note an accepted input beat; a beat marked last releases the whole set
    function void take_record(in_beat_t b);
      rec_t r;
      int pos;
      out_beat_t row;
      logic [ScoreW-1:0] threshold;
      if (roster.size() >= capacity) begin
        dropped = 1'b1;
      end else begin
        // first record always sets the best, later ones only when strictly higher
        if (roster.size() == 0 || b.score > top_score) begin
          top_score = b.score;
          top_tag = b.record_tag;
        end
        r.key = b.sort_key;
        r.score = b.score;
        r.tag = b.record_tag;
        // goes after every stored key less than or equal to its own
        pos = roster.size();
        while (pos > 0 && roster[pos-1].key > b.sort_key) pos--;
        roster.insert(pos, r);
      end
      if (b.is_last) begin
        threshold = total_score >> 1;
        foreach (roster[k]) begin
          row.out_tag = roster[k].tag;
          row.out_score = roster[k].score;
          row.passed = (roster[k].score >= threshold);
          row.best_score = top_score;
          row.best_tag = top_tag;
          row.overflowed = dropped;
          row.last_out = (k == roster.size() - 1);
          expected_rows.push_back(row);
        end
        roster.delete();
        top_score = '0;
        top_tag = '0;
        dropped = 1'b0;
      end
    endfunction

    // compare one accepted output beat with the oldest predicted row
    function void check_row(out_beat_t got);
      out_beat_t want;
      if (expected_rows.size() == 0) begin
        $error("output beat with no row pending: %p", got);
        mismatches++;
        return;
      end
      want = expected_rows.pop_front();
      if (got.out_tag !== want.out_tag) begin
        $error("out_tag: expected %0d, actual %0d", want.out_tag, got.out_tag);
        mismatches++;
      end
      if (got.out_score !== want.out_score) begin
        $error("out_score: expected %0d, actual %0d", want.out_score, got.out_score);
        mismatches++;
      end
      if (got.passed !== want.passed) begin
        $error("passed: expected %0d, actual %0d", want.passed, got.passed);
        mismatches++;
      end
      if (got.best_score !== want.best_score) begin
        $error("best_score: expected %0d, actual %0d", want.best_score, got.best_score);
        mismatches++;
      end
      if (got.best_tag !== want.best_tag) begin
        $error("best_tag: expected %0d, actual %0d", want.best_tag, got.best_tag);
        mismatches++;
      end
      if (got.overflowed !== want.overflowed) begin
        $error("overflowed: expected %0d, actual %0d", want.overflowed, got.overflowed);
        mismatches++;
      end
      if (got.last_out !== want.last_out) begin
        $error("last_out: expected %0d, actual %0d", want.last_out, got.last_out);
        mismatches++;
      end
    endfunction
  endclass

endpackage

### dv/tb_top.sv
// testbench top: drives record sets into the sorter and checks the sorted rows
module tb_top;
  import srs_pkg::*;
  import srs_tb_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int SettleCycles = 6;
  localparam int RandomItems = 350;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_HALF,
    STALL_HEAVY
  } stall_mode_e;

  typedef enum logic [1:0] {
    KEYS_RANDOM,
    KEYS_NARROW,
    KEYS_RISING,
    KEYS_FALLING
  } key_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [ScoreW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  in_beat_t in_data = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  out_beat_t out_data_o;

  sorted_roster book = new(MaxRecordsDef);
  int idle_cycles = 0;
  int burst_left = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int stall_mode_left = 0;

  stable_record_sorter_with_max dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // receiver stall pattern, switching between quiet, half and heavy stretches
  always @(posedge clk_i) begin
    if (stall_mode_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 2));
      stall_mode_left <= $urandom_range(10, 60);
    end else begin
      stall_mode_left <= stall_mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_HALF: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // check every accepted output beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) book.check_row(out_data_o);
  end

  // cycles with no beat accepted on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // watchdog
  initial begin
    wait (idle_cycles >= IdleLimit);
    $display("FAIL");
    $finish;
  end

  // hold one input beat until it is taken
  task automatic send_record(input in_beat_t b);
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    book.take_record(b);
  endtask

  // sender bursts with random gaps in between
  task automatic add_record(input logic [KeyW-1:0] key, input logic [ScoreW-1:0] score,
                            input logic [TagW-1:0] tag, input logic last);
    in_beat_t b;
    b.sort_key = key;
    b.score = score;
    b.record_tag = tag;
    b.is_last = last;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 8);
    end
    burst_left--;
    send_record(b);
  endtask

  // let every predicted row come out, then let the block settle
  task automatic drain_rows();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_total(input logic [ScoreW-1:0] value);
    drain_rows();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    book.set_total(value);
  endtask

  initial begin
    int sent;
    int set_no;
    int set_size;
    int thr;
    int pick;
    key_mode_e key_mode;
    logic [KeyW-1:0] key_base;
    logic [KeyW-1:0] key;
    logic [ScoreW-1:0] score;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset threshold of 50: boundary scores, equal keys, tie on the best score
    add_record(8'h41, 10'd49, 6'd1, 1'b0);
    add_record(8'h41, 10'd50, 6'd2, 1'b0);
    add_record(8'h00, 10'd0, 6'd0, 1'b0);
    add_record(8'hFF, 10'd1023, 6'd63, 1'b0);
    add_record(8'h41, 10'd1023, 6'd5, 1'b0);
    add_record(8'h80, 10'd51, 6'd42, 1'b1);
    // one record set, zero score still becomes the best
    add_record(8'hFF, 10'd0, 6'd63, 1'b1);

    // zero total: everything passes; keys arrive in falling order
    write_total(10'd0);
    add_record(8'hFF, 10'd0, 6'h15, 1'b0);
    add_record(8'h7F, 10'd0, 6'h2A, 1'b0);
    add_record(8'h01, 10'd0, 6'h3F, 1'b1);

    // full total: threshold 511
    write_total(10'd1023);
    add_record(8'h10, 10'd511, 6'h0A, 1'b0);
    add_record(8'h10, 10'd510, 6'h0B, 1'b0);
    add_record(8'h10, 10'd1023, 6'h0C, 1'b0);
    add_record(8'h0F, 10'd512, 6'h0D, 1'b1);

    // total of one rounds down to zero
    write_total(10'd1);
    add_record(8'h55, 10'd0, 6'd0, 1'b1);

    // random sets; the first two fill the store exactly and overflow it
    sent = 0;
    set_no = 0;
    while (sent < RandomItems) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        case ($urandom_range(0, 4))
          0: write_total(10'd0);
          1: write_total(10'd1023);
          2: write_total(10'd1);
          default: write_total(10'($urandom_range(0, 1023)));
        endcase
      end else if (pick == 1) begin
        drain_rows();
      end

      if (set_no == 0) set_size = MaxRecordsDef;
      else if (set_no == 1) set_size = MaxRecordsDef + 6;
      else if ($urandom_range(0, 14) == 0) set_size = $urandom_range(60, 72);
      else set_size = $urandom_range(1, 9);

      key_mode = key_mode_e'($urandom_range(0, 3));
      key_base = 8'($urandom_range(0, 255));
      thr = int'(book.total_score) / 2;
      for (int i = 0; i < set_size; i++) begin
        case (key_mode)
          KEYS_RANDOM: key = 8'($urandom_range(0, 255));
          KEYS_NARROW: key = key_base + 8'($urandom_range(0, 3));
          KEYS_RISING: key = key_base + 8'(i);
          default: key = key_base - 8'(i * 3);
        endcase
        case ($urandom_range(0, 9))
          0: score = '0;
          1: score = '1;
          2, 3: score = 10'(thr + int'($urandom_range(0, 2)) - 1);
          default: score = 10'($urandom_range(0, 1023));
        endcase
        add_record(key, score, 6'($urandom_range(0, 63)), i == set_size - 1);
      end
      sent += set_size;
      set_no++;
    end

    // wind down
    drain_rows();
    if (book.pending() != 0) begin
      $error("%0d sorted rows never came out", book.pending());
    end
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
